// ----- hw/rtl/ssrf_pkg.sv -----
`default_nettype none

package ssrf_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_ACCEPTED     = 3'd0,
        STATUS_HELD         = 3'd1,
        STATUS_FORCED       = 3'd2,
        STATUS_SENSOR_FAIL  = 3'd3,
        STATUS_OUT_OF_RANGE = 3'd4
    } status_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_CHANGE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ANOMALY_LIMIT    = 3'd1;
    localparam logic [2:0] REG_TEMP_LOW         = 3'd2;
    localparam logic [2:0] REG_TEMP_HIGH        = 3'd3;
    localparam logic [2:0] REG_HUM_LOW          = 3'd4;
    localparam logic [2:0] REG_HUM_HIGH         = 3'd5;

    // Configuration reset values.
    localparam logic [15:0]        RST_CHANGE_THRESHOLD = 16'd30;
    localparam logic [3:0]         RST_ANOMALY_LIMIT    = 4'd3;
    localparam logic signed [15:0] RST_TEMP_LOW         = -16'sd400;
    localparam logic signed [15:0] RST_TEMP_HIGH        = 16'sd800;
    localparam logic [15:0]        RST_HUM_LOW          = 16'd0;
    localparam logic [15:0]        RST_HUM_HIGH         = 16'd1000;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [4:0]  RUN_MAX = 5'd31;

    // One result transaction.
    typedef struct packed {
        logic [15:0]        read_total;
        logic [15:0]        error_total;
        logic [15:0]        anomaly_total;
        logic [4:0]         consec_anomalies;
        logic               has_reading;
        logic [15:0]        out_hum;
        logic signed [15:0] out_temp;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sensor_spike_reject_filter.sv -----
`default_nettype none

// Spike rejection filter for paired temperature and humidity readings in tenths
// of a unit. Each input transaction yields exactly one result transaction. A
// failed read or a reading outside the configured inclusive ranges counts as an
// error and leaves the output pair unchanged. A reading whose temperature or
// humidity jumps from the last valid pair by more than the change threshold is
// held back and replaced by that pair, until more than anomaly_limit such
// readings arrive in a row; that one is then taken as the new valid pair. All
// counters saturate at their maximum. The block accepts one reading per clock
// cycle while the skid entry is empty. Each result is decided by a single stage
// of compare and subtract logic on the filter state and is then registered. A
// two-entry output register lets one more reading in while the output side
// stalls. Configuration registers must be written only while idle.
module sensor_spike_reject_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    // Input readings.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // temp_sample[15:0], hum_sample[31:16]
    input  wire logic [0:0]  s_axis_tuser,  // sensor_ok[0]

    // Filtered results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_temp[15:0], out_hum[31:16], has_reading[32], consec_anomalies[37:33],
    // anomaly_total[53:38], error_total[69:54], read_total[85:70], zero[87:86]
    output logic [87:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser   // status[2:0]
);
    import ssrf_pkg::*;

    // Configuration registers.
    logic [15:0]        change_threshold_reg;
    logic [3:0]         anomaly_limit_reg;
    logic signed [15:0] temp_low_reg;
    logic signed [15:0] temp_high_reg;
    logic [15:0]        hum_low_reg;
    logic [15:0]        hum_high_reg;

    // Filter state. The output pair always equals the last valid pair.
    logic signed [15:0] valid_temp_reg, valid_temp_next;
    logic [15:0]        valid_hum_reg, valid_hum_next;
    logic               have_valid_reg, have_valid_next;
    logic [4:0]         run_count_reg, run_count_next;
    logic [15:0]        anomaly_count_reg, anomaly_count_next;
    logic [15:0]        error_count_reg, error_count_next;
    logic [15:0]        read_count_reg, read_count_next;

    // Output register and skid entry.
    result_t out_reg, out_next;
    status_t out_status_reg, out_status_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    status_t skid_status_reg, skid_status_next;
    logic    skid_valid_reg, skid_valid_next;

    logic               in_accept;
    logic               sensor_ok;
    logic signed [15:0] temp_in;
    logic [15:0]        hum_in;
    logic               out_of_range;
    logic signed [16:0] temp_diff;
    logic [15:0]        temp_dist;
    logic [15:0]        hum_dist;
    logic               is_anomaly;
    logic [4:0]         run_inc;
    status_t            status;
    result_t            result;

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign sensor_ok     = s_axis_tuser[0];
    assign temp_in       = s_axis_tdata[15:0];
    assign hum_in        = s_axis_tdata[31:16];

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_threshold_reg <= RST_CHANGE_THRESHOLD;
            anomaly_limit_reg    <= RST_ANOMALY_LIMIT;
            temp_low_reg         <= RST_TEMP_LOW;
            temp_high_reg        <= RST_TEMP_HIGH;
            hum_low_reg          <= RST_HUM_LOW;
            hum_high_reg         <= RST_HUM_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANGE_THRESHOLD: change_threshold_reg <= cfg_data;
                REG_ANOMALY_LIMIT:    anomaly_limit_reg    <= cfg_data[3:0];
                REG_TEMP_LOW:         temp_low_reg         <= cfg_data;
                REG_TEMP_HIGH:        temp_high_reg        <= cfg_data;
                REG_HUM_LOW:          hum_low_reg          <= cfg_data;
                REG_HUM_HIGH:         hum_high_reg         <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Range check and absolute jump from the last valid pair.
    always_comb
    begin
        out_of_range = (temp_in < temp_low_reg) || (temp_in > temp_high_reg) ||
                       (hum_in < hum_low_reg) || (hum_in > hum_high_reg);
        temp_diff    = 17'(temp_in) - 17'(valid_temp_reg);
        temp_dist    = temp_diff[16] ? 16'(-temp_diff) : temp_diff[15:0];
        hum_dist     = (hum_in >= valid_hum_reg) ? (hum_in - valid_hum_reg)
                                                 : (valid_hum_reg - hum_in);
        is_anomaly   = (temp_dist > change_threshold_reg) ||
                       (hum_dist > change_threshold_reg);
        run_inc      = (run_count_reg < RUN_MAX) ? (run_count_reg + 5'd1) : RUN_MAX;
    end

    // Next filter state for the accepted reading.
    always_comb
    begin
        valid_temp_next    = valid_temp_reg;
        valid_hum_next     = valid_hum_reg;
        have_valid_next    = have_valid_reg;
        run_count_next     = run_count_reg;
        anomaly_count_next = anomaly_count_reg;
        error_count_next   = error_count_reg;
        read_count_next    = (read_count_reg < CNT_MAX) ? (read_count_reg + 16'd1) : CNT_MAX;
        status             = STATUS_ACCEPTED;

        priority if (!sensor_ok)
        begin
            error_count_next = (error_count_reg < CNT_MAX) ? (error_count_reg + 16'd1)
                                                           : CNT_MAX;
            status           = STATUS_SENSOR_FAIL;
        end
        else if (out_of_range)
        begin
            error_count_next = (error_count_reg < CNT_MAX) ? (error_count_reg + 16'd1)
                                                           : CNT_MAX;
            status           = STATUS_OUT_OF_RANGE;
        end
        else if (!have_valid_reg || !is_anomaly)
        begin
            // First reading, or a jump within the threshold.
            valid_temp_next = temp_in;
            valid_hum_next  = hum_in;
            have_valid_next = 1'b1;
            if (have_valid_reg)
            begin
                run_count_next = 5'd0;
            end
            status = STATUS_ACCEPTED;
        end
        else
        begin
            anomaly_count_next = (anomaly_count_reg < CNT_MAX)
                                 ? (anomaly_count_reg + 16'd1) : CNT_MAX;
            if (run_inc > 5'(anomaly_limit_reg))
            begin
                // Run is long enough: take the reading as real.
                run_count_next  = 5'd0;
                valid_temp_next = temp_in;
                valid_hum_next  = hum_in;
                status          = STATUS_FORCED;
            end
            else
            begin
                run_count_next = run_inc;
                status         = STATUS_HELD;
            end
        end

        result.out_temp         = valid_temp_next;
        result.out_hum          = valid_hum_next;
        result.has_reading      = have_valid_next;
        result.consec_anomalies = run_count_next;
        result.anomaly_total    = anomaly_count_next;
        result.error_total      = error_count_next;
        result.read_total       = read_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_temp_reg    <= '0;
            valid_hum_reg     <= '0;
            have_valid_reg    <= 1'b0;
            run_count_reg     <= '0;
            anomaly_count_reg <= '0;
            error_count_reg   <= '0;
            read_count_reg    <= '0;
        end
        else if (in_accept)
        begin
            valid_temp_reg    <= valid_temp_next;
            valid_hum_reg     <= valid_hum_next;
            have_valid_reg    <= have_valid_next;
            run_count_reg     <= run_count_next;
            anomaly_count_reg <= anomaly_count_next;
            error_count_reg   <= error_count_next;
            read_count_reg    <= read_count_next;
        end
    end

    // Output register with one skid entry; results leave in order.
    always_comb
    begin
        out_next         = out_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg;
        skid_next        = skid_reg;
        skid_status_next = skid_status_reg;
        skid_valid_next  = skid_valid_reg;

        if (out_valid_reg && !m_axis_tready)
        begin
            if (in_accept)
            begin
                skid_next        = result;
                skid_status_next = status;
                skid_valid_next  = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_next         = skid_reg;
            out_status_next  = skid_status_reg;
            out_valid_next   = 1'b1;
            skid_next        = result;
            skid_status_next = status;
            skid_valid_next  = in_accept;
        end
        else
        begin
            out_next        = result;
            out_status_next = status;
            out_valid_next  = in_accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        out_status_reg  <= out_status_next;
        skid_reg        <= skid_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ----- test/tb_sensor_spike_reject_filter.sv -----
`default_nettype none

module tb_sensor_spike_reject_filter;
    import ssrf_pkg::*;

    localparam int CYCLE_LIMIT = 40000;
    localparam int PRINT_LIMIT = 100;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // One expected result: the data fields plus the status code.
    typedef struct {
        result_t fields;
        status_t status;
    } filter_result_t;

    // Predicts the filter output for each reading and checks the results in order.
    class reading_scoreboard;
        // Configuration copy.
        logic [15:0]        threshold;
        logic [3:0]         limit;
        logic signed [15:0] temp_lo;
        logic signed [15:0] temp_hi;
        logic [15:0]        hum_lo;
        logic [15:0]        hum_hi;

        // Filter state.
        logic signed [15:0] valid_t;
        logic [15:0]        valid_h;
        bit                 have_valid;
        logic signed [15:0] shown_t;
        logic [15:0]        shown_h;
        logic [4:0]         run;
        logic [15:0]        anomalies;
        logic [15:0]        errors;
        logic [15:0]        reads;

        filter_result_t     expected_q[$];
        int                 failures;
        int                 results_seen;

        function new();
            threshold = RST_CHANGE_THRESHOLD;
            limit = RST_ANOMALY_LIMIT;
            temp_lo = RST_TEMP_LOW;
            temp_hi = RST_TEMP_HIGH;
            hum_lo = RST_HUM_LOW;
            hum_hi = RST_HUM_HIGH;
            valid_t = '0;
            valid_h = '0;
            have_valid = 1'b0;
            shown_t = '0;
            shown_h = '0;
            run = '0;
            anomalies = '0;
            errors = '0;
            reads = '0;
            failures = 0;
            results_seen = 0;
        endfunction

        function void apply_write(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_CHANGE_THRESHOLD: threshold = value;
                REG_ANOMALY_LIMIT:    limit = value[3:0];
                REG_TEMP_LOW:         temp_lo = value;
                REG_TEMP_HIGH:        temp_hi = value;
                REG_HUM_LOW:          hum_lo = value;
                REG_HUM_HIGH:         hum_hi = value;
                default:              ;
            endcase
        endfunction

        function logic [15:0] bump(logic [15:0] count);
            return (count == CNT_MAX) ? count : count + 16'd1;
        endfunction

        function void take_pair(logic signed [15:0] t, logic [15:0] h);
            valid_t = t;
            valid_h = h;
            shown_t = t;
            shown_h = h;
            have_valid = 1'b1;
        endfunction

        // Advance the filter state by one accepted reading and queue its result.
        function void note_reading(bit ok, logic signed [15:0] t, logic [15:0] h);
            int             dt;
            int             dh;
            status_t        st;
            filter_result_t exp_item;

            reads = bump(reads);
            if (!ok)
            begin
                errors = bump(errors);
                st = STATUS_SENSOR_FAIL;
            end
            else if (t < temp_lo || t > temp_hi || h < hum_lo || h > hum_hi)
            begin
                errors = bump(errors);
                st = STATUS_OUT_OF_RANGE;
            end
            else if (!have_valid)
            begin
                take_pair(t, h);
                st = STATUS_ACCEPTED;
            end
            else
            begin
                // Differences are taken at full width so that nothing wraps.
                dt = int'(t) - int'(valid_t);
                dh = int'(h) - int'(valid_h);
                if (dt < 0)
                    dt = -dt;
                if (dh < 0)
                    dh = -dh;
                if (dt > int'(threshold) || dh > int'(threshold))
                begin
                    if (run != RUN_MAX)
                        run = run + 5'd1;
                    anomalies = bump(anomalies);
                    if (run > limit)
                    begin
                        run = '0;
                        take_pair(t, h);
                        st = STATUS_FORCED;
                    end
                    else
                    begin
                        shown_t = valid_t;
                        shown_h = valid_h;
                        st = STATUS_HELD;
                    end
                end
                else
                begin
                    run = '0;
                    take_pair(t, h);
                    st = STATUS_ACCEPTED;
                end
            end

            exp_item.fields.out_temp = shown_t;
            exp_item.fields.out_hum = shown_h;
            exp_item.fields.has_reading = have_valid;
            exp_item.fields.consec_anomalies = run;
            exp_item.fields.anomaly_total = anomalies;
            exp_item.fields.error_total = errors;
            exp_item.fields.read_total = reads;
            exp_item.status = st;
            expected_q.push_back(exp_item);
        endfunction

        // Print one line per mismatch; the count keeps going past the print cap.
        task report_mismatch(string msg);
            failures++;
            if (failures <= PRINT_LIMIT)
                $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic signed [31:0] got, logic signed [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                          results_seen, name, got, want));
        endtask

        // Compare one result transaction with the oldest expectation.
        task check_result(logic [87:0] data, logic [2:0] user);
            filter_result_t exp_item;
            result_t        got;

            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no reading pending",
                                          results_seen));
                return;
            end
            exp_item = expected_q.pop_front();
            got = result_t'(data[85:0]);
            compare_field("out_temp", 32'($signed(got.out_temp)),
                          32'($signed(exp_item.fields.out_temp)));
            compare_field("out_hum", 32'(got.out_hum), 32'(exp_item.fields.out_hum));
            compare_field("has_reading", 32'(got.has_reading),
                          32'(exp_item.fields.has_reading));
            compare_field("consec_anomalies", 32'(got.consec_anomalies),
                          32'(exp_item.fields.consec_anomalies));
            compare_field("anomaly_total", 32'(got.anomaly_total),
                          32'(exp_item.fields.anomaly_total));
            compare_field("error_total", 32'(got.error_total),
                          32'(exp_item.fields.error_total));
            compare_field("read_total", 32'(got.read_total),
                          32'(exp_item.fields.read_total));
            compare_field("status", 32'(user), 32'(exp_item.status));
            compare_field("padding", 32'(data[87:86]), 0);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // temp_sample[15:0], hum_sample[31:16]
    logic [0:0]  s_axis_tuser = '0;  // sensor_ok[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_temp[15:0], out_hum[31:16], has_reading[32], consec_anomalies[37:33],
    // anomaly_total[53:38], error_total[69:54], read_total[85:70], zero[87:86]
    logic [87:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;      // status[2:0]

    reading_scoreboard sb = new();
    int                cycle_count = 0;
    bit                sender_steady = 1'b0;
    bit                receiver_steady = 1'b0;
    int                hold_request = 0;

    sensor_spike_reject_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, an occasional long hold-off, then one transaction.
    initial
    begin
        int stall;
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = receiver_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    function int pick_between(int lo, int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function int clamp(int v, int lo, int hi);
        if (hi < lo)
            return v;
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Offer one reading after a random gap and wait until it is taken.
    task send_reading(bit ok, logic signed [15:0] t, logic [15:0] h);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {h, t};
        s_axis_tuser <= ok;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_reading(ok, t, h);
    endtask

    // Stop offering and let every outstanding result drain.
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all registers, plus the two unused indexes, in back-to-back cycles.
    task load_settings(int thr, int lim, int tlo, int thi, int hlo, int hhi);
        logic [15:0] value [8];
        value[REG_CHANGE_THRESHOLD] = 16'(thr);
        value[REG_ANOMALY_LIMIT] = {12'($urandom), 4'(lim)};
        value[REG_TEMP_LOW] = 16'(tlo);
        value[REG_TEMP_HIGH] = 16'(thi);
        value[REG_HUM_LOW] = 16'(hlo);
        value[REG_HUM_HIGH] = 16'(hhi);
        value[REG_SPARE_A] = 16'($urandom);
        value[REG_SPARE_B] = 16'($urandom);
        cfg_we <= 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            cfg_index <= 3'(i);
            cfg_data <= value[i];
            @(posedge clk);
            sb.apply_write(3'(i), value[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random readings: mostly small steps around the last valid pair, with
    // jumps, range boundaries, sensor failures and raw noise mixed in.
    task random_readings(int count, int hold_at);
        int pick;
        int span;
        int tv;
        int hv;
        int tlo;
        int thi;
        int hlo;
        int hhi;
        bit ok;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_request = 60;
            tlo = int'(sb.temp_lo);
            thi = int'(sb.temp_hi);
            hlo = int'(sb.hum_lo);
            hhi = int'(sb.hum_hi);
            ok = 1'b1;
            tv = pick_between(tlo, thi);
            hv = pick_between(hlo, hhi);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                ok = 1'b0;
                tv = $urandom;
                hv = $urandom;
            end
            else if (pick < 16)
            begin
                tv = $urandom;
                hv = $urandom;
            end
            else if (pick < 26)
            begin
                case ($urandom_range(0, 3))
                    0: tv = tlo - 1;
                    1: tv = tlo;
                    2: tv = thi;
                    default: tv = thi + 1;
                endcase
                case ($urandom_range(0, 3))
                    0: hv = hlo - 1;
                    1: hv = hlo;
                    2: hv = hhi;
                    default: hv = hhi + 1;
                endcase
            end
            else if (pick >= 40 && sb.have_valid)
            begin
                span = (sb.threshold > 16'd2000) ? 2000 : int'(sb.threshold) + 2;
                tv = clamp(int'(sb.valid_t) + int'($urandom_range(0, 2 * span)) - span,
                           tlo, thi);
                hv = clamp(int'(sb.valid_h) + int'($urandom_range(0, 2 * span)) - span,
                           hlo, hhi);
            end
            send_reading(ok, 16'(tv), 16'(hv));
        end
    endtask

    initial
    begin
        int a;
        int b;
        int c;
        int d;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed readings against the reset configuration.
        send_reading(1'b0, 16'sd0, 16'd0);        // failure before any acceptance
        send_reading(1'b1, -16'sd401, 16'd500);   // temperature just below range
        send_reading(1'b1, 16'sd100, 16'd1001);   // humidity just above range
        send_reading(1'b0, 16'sd5000, 16'd5000);  // failure outranks the range check
        send_reading(1'b1, 16'sd800, 16'd1000);   // first good reading, upper bounds
        send_reading(1'b1, 16'sd770, 16'd970);    // jump equal to the threshold
        send_reading(1'b1, 16'sd739, 16'd970);    // jump one past it: held
        send_reading(1'b0, 16'sd739, 16'd970);    // error leaves the run alone
        send_reading(1'b1, 16'sd801, 16'd970);    // temperature just above range
        send_reading(1'b1, 16'sd770, 16'd901);    // humidity jump: held
        send_reading(1'b1, -16'sd400, 16'd0);     // lower bounds, still held
        send_reading(1'b1, -16'sd400, 16'd0);     // run passes the limit: forced
        send_reading(1'b1, -16'sd390, 16'd10);

        // Full range and the widest threshold.
        wait_idle();
        load_settings(65535, 0, -32768, 32767, 0, 65535);
        send_reading(1'b1, -16'sd32768, 16'd0);
        send_reading(1'b1, 16'sd32767, 16'd65535);
        send_reading(1'b1, -16'sd32768, 16'd0);

        // Zero threshold with no tolerance for anomalies.
        wait_idle();
        load_settings(0, 0, -32768, 32767, 0, 65535);
        send_reading(1'b1, -16'sd32768, 16'd0);
        send_reading(1'b1, -16'sd32767, 16'd0);

        // Empty ranges reject everything.
        wait_idle();
        load_settings(30, 3, 100, -100, 0, 65535);
        send_reading(1'b1, 16'sd0, 16'd500);
        send_reading(1'b1, 16'sd100, 16'd500);
        wait_idle();
        load_settings(30, 3, -32768, 32767, 600, 500);
        send_reading(1'b1, 16'sd0, 16'd550);

        // Random phases, each with its own configuration.
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
            c = $urandom_range(0, 65535);
            d = $urandom_range(0, 65535);
            case (phase)
                0: load_settings(int'(RST_CHANGE_THRESHOLD), int'(RST_ANOMALY_LIMIT),
                                 int'(RST_TEMP_LOW), int'(RST_TEMP_HIGH),
                                 int'(RST_HUM_LOW), int'(RST_HUM_HIGH));
                1: load_settings(0, 0, -32768, 32767, 0, 65535);
                2: load_settings(65535, 15, -32768, 32767, 0, 65535);
                3: load_settings($urandom_range(0, 100), $urandom_range(0, 15),
                                 (a < b) ? a : b, (a < b) ? b : a,
                                 (c < d) ? c : d, (c < d) ? d : c);
                4: load_settings(5, 15, -50, 50, 100, 200);
                5: load_settings($urandom_range(0, 65535), $urandom_range(0, 15), a, b, c, d);
                default: load_settings($urandom_range(0, 3000), $urandom_range(0, 15),
                                       (a < b) ? a : b, (a < b) ? b : a,
                                       (c < d) ? c : d, (c < d) ? d : c);
            endcase
            sender_steady = (phase == 3) || (phase % 3 == 2);
            receiver_steady = (phase % 3 == 2);
            random_readings(65, (phase == 3) ? 20 : -1);
        end

        wait_idle();
        repeat (5) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
